// ===== src/vfpq_pkg.sv =====
// shared constants and types of the vip-first priority queue
package vfpq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int INDEX_W = $clog2(DEPTH);

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic              vip;
        logic [DATA_W-1:0] data;
    } t_slot;

    // per-cycle control handed to every cell
    typedef struct packed {
        logic occ;       // cell holds a live entry
        logic push_here; // the pushed entry lands in this cell
        logic pop_en;    // an accepted pop on a non-empty queue
        logic any_vip;   // some live entry carries the vip mark
        logic is_head;   // cell at the front of the row
    } t_cell_ctl;

endpackage

// ===== src/vfpq_cell.sv =====
// one slot of the queue: holds an entry, finds the oldest vip, shifts forward
module vfpq_cell
    import vfpq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_push_slot,
    input  t_slot     i_next_slot,
    input  logic      i_seen,
    output logic      o_seen,
    output t_slot     o_slot,
    output t_slot     o_pick_slot
);

    t_slot r_slot;
    logic  vip_live;
    logic  pick;
    logic  shift;

    assign vip_live = i_ctl.occ & r_slot.vip;
    assign o_seen   = i_seen | vip_live;

    // picked: oldest live vip, or the head when no vip is held
    assign pick  = i_ctl.pop_en & (i_ctl.any_vip ? (vip_live & ~i_seen) : i_ctl.is_head);
    // cells from the picked one on take their neighbor's entry
    assign shift = i_ctl.pop_en & (~i_ctl.any_vip | o_seen);

    // stored entry, handed to the cell in front on a shift
    assign o_slot      = r_slot;
    assign o_pick_slot = pick ? r_slot : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_here) begin
            r_slot <= i_push_slot;
        end else if (shift) begin
            r_slot <= i_next_slot;
        end
    end

endmodule

// ===== src/vip_first_priority_queue_unit.sv =====
// top level of the vip-first priority queue
//
// usage
//   a request is taken at a rising edge with start high and busy low; i_func
//   selects push (i_entry_data, i_entry_vip appended at the tail) or pop
//   (oldest vip entry removed, else the oldest entry)
//   in the cycle after the request o_done pulses for one cycle with o_out_data,
//   o_out_vip, o_out_valid, o_dropped and o_fill_count
//   throughput 1 request per cycle outside reset: the whole update is one
//   pass through the row of cells, set by the vip-seen chain that ripples
//   from the head cell to the tail cell
//   a push on a full queue or a pop on an empty one sets o_dropped and
//   leaves the queue as it was
//   reset (synchronous, active low) empties the queue and clears o_done;
//   busy is high while reset is asserted, so no request is taken then
//   slot contents are not cleared: only slots below the fill count are read
//   the receiver cannot stall, each result is shown for exactly one cycle
module vip_first_priority_queue_unit
    import vfpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_entry_data,
    input  logic        i_entry_vip,
    output logic        o_done,
    output logic [31:0] o_out_data,
    output logic        o_out_vip,
    output logic        o_out_valid,
    output logic        o_dropped,
    output logic [4:0]  o_fill_count
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_done;
    logic [DATA_W-1:0]  r_data;
    logic               r_vip, r_valid, r_drop;

    logic      accept;
    logic      push_ok, pop_ok;
    logic      full, empty;
    t_slot     push_slot;
    t_slot     pick_slot;
    logic      seen   [DEPTH+1];
    t_slot     picks  [DEPTH];
    t_slot     nexts  [DEPTH];
    t_slot     cur    [DEPTH];
    t_cell_ctl ctl    [DEPTH];

    // no request during reset
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    assign full    = (r_count == COUNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = accept & (i_func == FUNC_PUSH) & ~full;
    assign pop_ok  = accept & (i_func == FUNC_POP) & ~empty;

    assign push_slot.vip  = i_entry_vip;
    assign push_slot.data = i_entry_data[DATA_W-1:0];

    // vip-seen chain enters at the head
    assign seen[0] = 1'b0;

    // chain end tells whether any live vip exists
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ctl[i].occ       = (COUNT_W'(i) < r_count);
            ctl[i].push_here = push_ok & (COUNT_W'(i) == r_count);
            ctl[i].pop_en    = pop_ok;
            ctl[i].any_vip   = seen[DEPTH];
            ctl[i].is_head   = (i == 0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            // the tail cell shifts in nothing useful: its slot falls out of range
            if (g == DEPTH - 1) begin : g_tail
                assign nexts[g] = '0;
            end else begin : g_mid
                assign nexts[g] = cur[g+1];
            end

            vfpq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl[g]),
                .i_push_slot (push_slot),
                .i_next_slot (nexts[g]),
                .i_seen      (seen[g]),
                .o_seen      (seen[g+1]),
                .o_slot      (cur[g]),
                .o_pick_slot (picks[g])
            );
        end
    endgenerate

    // one-hot pick, so an or of the masked slots gives the popped entry
    always_comb begin
        pick_slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pick_slot = pick_slot | picks[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + COUNT_W'(1);
        end else if (pop_ok) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data  <= pop_ok ? pick_slot.data : '0;
            r_vip   <= pop_ok & pick_slot.vip;
            r_valid <= pop_ok;
            r_drop  <= ~push_ok & ~pop_ok;
        end
    end

    assign o_done       = r_done;
    assign o_out_data   = 32'(r_data);
    assign o_out_vip    = r_vip;
    assign o_out_valid  = r_valid;
    assign o_dropped    = r_drop;
    assign o_fill_count = 5'(r_count);

endmodule

// ===== src/vfpq_checker.sv =====
// port-level checks of the vip-first priority queue and their bind
module vfpq_checker
    import vfpq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_out_valid,
    input logic        o_out_vip,
    input logic [31:0] o_out_data,
    input logic        o_dropped,
    input logic [4:0]  o_fill_count
);

    // every request gives exactly one result in the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without request");

    // a returned entry is never flagged as dropped
    a_valid_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_valid) |-> !o_dropped)
        else $error("valid pop also dropped");

    // a pop in back-to-back results lowers the fill count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && o_out_valid) |->
            (o_fill_count + 5'd1 == $past(o_fill_count)))
        else $error("pop did not lower the count by one");

    // a no-entry result carries zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_out_valid) |-> (o_out_data == 32'd0 && !o_out_vip))
        else $error("payload on a result without entry");

endmodule

bind vip_first_priority_queue_unit vfpq_checker u_vfpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_out_valid  (o_out_valid),
    .o_out_vip    (o_out_vip),
    .o_out_data   (o_out_data),
    .o_dropped    (o_dropped),
    .o_fill_count (o_fill_count)
);
